### hw/rtl/radix2_complex_fft_assert.svh
// Assertion macros for the FFT block
`ifndef RADIX2_COMPLEX_FFT_ASSERT_SVH
`define RADIX2_COMPLEX_FFT_ASSERT_SVH

`define R2F_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define R2F_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/r2fft_pkg.sv
`timescale 1ns / 1ps
package r2fft_pkg;
  localparam int LOG2_MAX_POINTS = 6;
  localparam int TWIDDLE_BITS = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int ACC_BITS = SAMPLE_BITS + LOG2_MAX_POINTS + 1;
  localparam int MAX_POINTS = 1 << LOG2_MAX_POINTS;
  localparam int ADDR_BITS = LOG2_MAX_POINTS;
  localparam int OUT_BITS = 23;
  localparam int STAGE_BITS = 3;
  localparam int PROD_BITS = ACC_BITS + TWIDDLE_BITS;

  localparam logic [0:0] REG_DIRECTION = 1'b0;
  localparam logic [0:0] REG_LOG2_POINTS = 1'b1;

  typedef logic signed [ACC_BITS-1:0] acc_t;
  typedef logic signed [TWIDDLE_BITS-1:0] twid_t;
  typedef logic [ADDR_BITS-1:0] addr_t;

  // controller to datapath
  typedef struct packed {
    logic  wr_load;     // write input sample at load_addr
    addr_t load_addr;
    addr_t rd_addr;     // both buffers read here every cycle
    logic  cap_a;       // capture read data as butterfly top
    logic  cap_b;       // capture read data as butterfly bottom
    logic  bf_mul;      // register twiddle products
    logic  wr_a;        // write a' at addr
    logic  wr_b;        // write b'
    addr_t wr_addr;
    logic [5:0] tw_idx;
    logic  direction;
  } r2f_cmd_t;

  function automatic logic [ADDR_BITS-1:0] bit_rev(input logic [ADDR_BITS-1:0] v,
                                                   input logic [STAGE_BITS-1:0] m);
    logic [ADDR_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < ADDR_BITS; i++) begin
      if (i < int'(m)) r[int'(m) - 1 - i] = v[i];
    end
    return r;
  endfunction

  // quarter sine at 1.0 = 2^23
  function automatic logic [23:0] qsine(input logic [4:0] k);
    logic [23:0] r;
    unique case (k)
      5'd0: r = 24'd0;        5'd1: r = 24'd822227;   5'd2: r = 24'd1636536;
      5'd3: r = 24'd2435084;  5'd4: r = 24'd3210181;  5'd5: r = 24'd3954362;
      5'd6: r = 24'd4660461;  5'd7: r = 24'd5321678;  5'd8: r = 24'd5931642;
      5'd9: r = 24'd6484482;  5'd10: r = 24'd6974873; 5'd11: r = 24'd7398092;
      5'd12: r = 24'd7750063; 5'd13: r = 24'd8027398; 5'd14: r = 24'd8227423;
      5'd15: r = 24'd8348215; 5'd16: r = 24'd8388608;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

  function automatic twid_t sine_at(input logic [5:0] t);
    logic [4:0] r;
    logic [23:0] mag0;
    logic [24:0] mag;
    logic [24:0] top;
    r = {1'b0, t[3:0]};
    mag0 = t[4] ? qsine(5'd16 - r) : qsine(r);
    mag = ({1'b0, mag0} + (25'd1 << (24 - TWIDDLE_BITS - 1))) >> (24 - TWIDDLE_BITS);
    top = (25'd1 << (TWIDDLE_BITS - 1)) - 25'd1;
    if (t[5]) return twid_t'(-$signed(mag));
    return (mag > top) ? twid_t'(top) : twid_t'(mag);
  endfunction
endpackage

### hw/rtl/r2fft_ram.sv
`timescale 1ns / 1ps
module r2fft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/r2fft_datapath.sv
`timescale 1ns / 1ps
module r2fft_datapath import r2fft_pkg::*; (
  input  logic                          clk,
  input  r2f_cmd_t                      cmd,
  input  logic signed [SAMPLE_BITS-1:0] in_re,
  input  logic signed [SAMPLE_BITS-1:0] in_im,
  input  logic [STAGE_BITS-1:0]         shift,
  output logic signed [OUT_BITS-1:0]    out_re,
  output logic signed [OUT_BITS-1:0]    out_im
);
  acc_t rd_re, rd_im;
  acc_t a_re, a_im, b_re, b_im;
  twid_t wr, wi;
  logic signed [PROD_BITS-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [PROD_BITS:0] t_re_full, t_im_full;
  acc_t t_re, t_im, wdata_re, wdata_im;
  logic we;
  logic signed [ACC_BITS:0] sr_re, sr_im;
  // capture strobes line up with registered read data
  logic cap_a_q, cap_b_q;

  r2fft_ram #(.WIDTH(ACC_BITS), .DEPTH(MAX_POINTS)) u_ram_re (
    .clk(clk), .we(we), .waddr(cmd.wr_load ? cmd.load_addr : cmd.wr_addr),
    .wdata(wdata_re), .raddr(cmd.rd_addr), .rdata(rd_re));
  r2fft_ram #(.WIDTH(ACC_BITS), .DEPTH(MAX_POINTS)) u_ram_im (
    .clk(clk), .we(we), .waddr(cmd.wr_load ? cmd.load_addr : cmd.wr_addr),
    .wdata(wdata_im), .raddr(cmd.rd_addr), .rdata(rd_im));

  always_comb begin
    wr = sine_at(cmd.tw_idx + 6'd16);
    wi = cmd.direction ? sine_at(cmd.tw_idx) : twid_t'(-sine_at(cmd.tw_idx));
  end

  always_ff @(posedge clk) begin
    if (cap_a_q) begin
      a_re <= rd_re;
      a_im <= rd_im;
    end
    if (cap_b_q) begin
      b_re <= rd_re;
      b_im <= rd_im;
    end
    if (cmd.bf_mul) begin
      p_rr <= PROD_BITS'(wr * b_re);
      p_ii <= PROD_BITS'(wi * b_im);
      p_ri <= PROD_BITS'(wr * b_im);
      p_ir <= PROD_BITS'(wi * b_re);
    end
  end

  always_ff @(posedge clk) begin
    cap_a_q <= cmd.cap_a;
    cap_b_q <= cmd.cap_b;
  end

  always_comb begin
    t_re_full = ($signed({p_rr[PROD_BITS-1], p_rr}) - $signed({p_ii[PROD_BITS-1], p_ii})
                 + (PROD_BITS+1)'(1 << (TWIDDLE_BITS - 2))) >>> (TWIDDLE_BITS - 1);
    t_im_full = ($signed({p_ri[PROD_BITS-1], p_ri}) + $signed({p_ir[PROD_BITS-1], p_ir})
                 + (PROD_BITS+1)'(1 << (TWIDDLE_BITS - 2))) >>> (TWIDDLE_BITS - 1);
    t_re = t_re_full[ACC_BITS-1:0];
    t_im = t_im_full[ACC_BITS-1:0];
    we = cmd.wr_load | cmd.wr_a | cmd.wr_b;
    if (cmd.wr_load) begin
      wdata_re = ACC_BITS'(in_re);
      wdata_im = ACC_BITS'(in_im);
    end else if (cmd.wr_a) begin
      wdata_re = a_re + t_re;
      wdata_im = a_im + t_im;
    end else begin
      wdata_re = a_re - t_re;
      wdata_im = a_im - t_im;
    end
    // output scaling: rounded arithmetic shift by m when direction is set, else unscaled
    if (cmd.direction) begin
      sr_re = ($signed({rd_re[ACC_BITS-1], rd_re}) + ((ACC_BITS+1)'(1) << shift)
               ) >>> (shift + STAGE_BITS'(1));
      sr_im = ($signed({rd_im[ACC_BITS-1], rd_im}) + ((ACC_BITS+1)'(1) << shift)
               ) >>> (shift + STAGE_BITS'(1));
    end else begin
      sr_re = {rd_re[ACC_BITS-1], rd_re};
      sr_im = {rd_im[ACC_BITS-1], rd_im};
    end
    out_re = sr_re[OUT_BITS-1:0];
    out_im = sr_im[OUT_BITS-1:0];
  end
endmodule

### hw/rtl/r2fft_ctrl.sv
`timescale 1ns / 1ps
module r2fft_ctrl import r2fft_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  logic                  out_stall,
  input  logic                  direction,
  input  logic [STAGE_BITS-1:0] m,
  input  logic                  restart,
  output r2f_cmd_t              cmd,
  output logic                  load_ready,
  output logic                  emit_valid,
  output logic                  emit_last
);
  typedef enum logic [2:0] {LOAD, RD_A, RD_B, WAIT, MUL, WR_A, WR_B, EMIT} state_t;
  state_t state;
  logic [ADDR_BITS:0] load_count;
  logic [STAGE_BITS-1:0] stage;
  logic [ADDR_BITS-1:0] bf;     // butterfly index within stage
  logic [ADDR_BITS:0] emit_idx; // next address to read
  logic rd_pend;                // read data for emit is valid
  logic dir_q;
  addr_t ia, ka, jmask;
  logic [ADDR_BITS-1:0] nm1;

  always_comb begin
    nm1 = ADDR_BITS'((1 << m) - 1);
    jmask = ADDR_BITS'((1 << stage) - 1);
    // top index: insert a zero at bit "stage" of bf
    ia = ((bf & ~jmask) << 1) | (bf & jmask);
    ka = ia | ADDR_BITS'(1 << stage);
  end

  always_comb begin
    cmd = '0;
    cmd.direction = dir_q;
    cmd.tw_idx = 6'((bf & jmask) << (3'd5 - stage));
    cmd.wr_addr = (state == WR_A) ? ia : ka;
    cmd.rd_addr = (state == RD_A) ? ia : ka;
    cmd.load_addr = bit_rev(load_count[ADDR_BITS-1:0] & nm1, m);
    cmd.wr_load = in_fire;
    unique case (state)
      RD_A: cmd.cap_a = 1'b1;
      RD_B: cmd.cap_b = 1'b1;
      MUL:  cmd.bf_mul = 1'b1;
      WR_A: cmd.wr_a = 1'b1;
      WR_B: cmd.wr_b = 1'b1;
      // hold the shown address while stalled, else fetch the next one
      EMIT: cmd.rd_addr = emit_idx[ADDR_BITS-1:0] - ADDR_BITS'(rd_pend && out_stall ? 1 : 0);
      default: ;
    endcase
    load_ready = (state == LOAD);
    emit_valid = (state == EMIT) && rd_pend;
    emit_last = emit_valid && (emit_idx == (ADDR_BITS+1)'(1 << m));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
      load_count <= '0;
      stage <= '0;
      bf <= '0;
      emit_idx <= '0;
      rd_pend <= 1'b0;
      dir_q <= 1'b0;
    end else if (restart && state == LOAD) begin
      load_count <= '0;
    end else begin
      unique case (state)
        LOAD: if (in_fire) begin
          if (load_count + 1'b1 == (ADDR_BITS+1)'(1 << m)) begin
            load_count <= '0;
            dir_q <= direction;
            stage <= '0;
            bf <= '0;
            state <= RD_A;
          end else begin
            load_count <= load_count + 1'b1;
          end
        end
        RD_A: state <= RD_B;
        RD_B: state <= WAIT;
        WAIT: state <= MUL;
        MUL:  state <= WR_A;
        WR_A: state <= WR_B;
        WR_B: begin
          if (bf == ADDR_BITS'((1 << (m - 1)) - 1)) begin
            bf <= '0;
            if (stage == m - 1'b1) begin
              state <= EMIT;
              emit_idx <= '0;
              rd_pend <= 1'b0;
            end else begin
              stage <= stage + 1'b1;
              state <= RD_A;
            end
          end else begin
            bf <= bf + 1'b1;
            state <= RD_A;
          end
        end
        EMIT: begin
          // read issued at emit_idx, data shown next cycle
          if (!rd_pend) begin
            rd_pend <= 1'b1;
            emit_idx <= emit_idx + 1'b1;
          end else if (!out_stall) begin
            if (emit_last) begin
              rd_pend <= 1'b0;
              state <= LOAD;
            end else begin
              emit_idx <= emit_idx + 1'b1;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end
endmodule

### hw/rtl/radix2_complex_fft.sv
`timescale 1ns / 1ps
// In-place radix-2 DIT FFT of 2..64 complex points. Samples load one per cycle
// into bit-reversed addresses; after the last one the block runs m stages of
// n/2 butterflies, each stepping through RD_A, RD_B, WAIT, MUL, WR_A and WR_B
// over shared real and imaginary buffers with one read and one write port
// each, then streams n results in natural order with last_out on the final
// bin. Input is held off (stall high) from the last sample until the last
// result is taken.
module radix2_complex_fft import r2fft_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [2:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_re,
  input  logic signed [SAMPLE_BITS-1:0] sample_im,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [OUT_BITS-1:0]    result_re,
  output logic signed [OUT_BITS-1:0]    result_im,
  output logic                          last_out
);
`include "radix2_complex_fft_assert.svh"
  logic direction;
  logic [2:0] log2_points;
  logic [STAGE_BITS-1:0] m;
  logic restart, load_ready, in_fire;
  r2f_cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      log2_points <= 3'd6;
    end else if (cfg_we) begin
      if (cfg_index == REG_DIRECTION) direction <= cfg_data[0];
      else log2_points <= cfg_data;
    end
  end

  assign restart = cfg_we && (cfg_index == REG_LOG2_POINTS);
  assign m = (log2_points == 3'd0) ? 3'd1 :
             (log2_points > 3'(LOG2_MAX_POINTS)) ? 3'(LOG2_MAX_POINTS) : log2_points;
  assign in_stall = !load_ready;
  assign in_fire = in_valid && load_ready;

  r2fft_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_stall(out_stall),
    .direction(direction), .m(m), .restart(restart), .cmd(cmd),
    .load_ready(load_ready), .emit_valid(out_valid), .emit_last(last_out));

  r2fft_datapath u_dp (
    .clk(clk), .cmd(cmd), .in_re(sample_re), .in_im(sample_im), .shift(m - 3'd1),
    .out_re(result_re), .out_im(result_im));

  `R2F_ASSERT_IMPL(a_no_overlap, clk, rst, out_valid, in_stall, "output during load")
  `R2F_ASSERT_IMPL(a_last_valid, clk, rst, last_out, out_valid, "last without valid")
  `R2F_ASSERT_NEXT(a_last_ends, clk, rst, out_valid && last_out && !out_stall,
                   !out_valid, "results after last")
endmodule
